### hdl/cbf_pkg.sv
package cbf_pkg;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_OPEN_COMMENT = 2'd1,
        ERR_OPEN_STRING  = 2'd2
    } t_err;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] error_code;
    } t_out;

    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_push;

    function automatic logic [7:0] blank(input logic [7:0] b);
        logic ws;
        ws = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
             (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
        return ws ? b : CH_SPACE;
    endfunction

endpackage

### hdl/cbf_scan.sv
module cbf_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  cbf_pkg::t_in  i_item,
    output cbf_pkg::t_push o_push
);

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_LINE       = 3'd1,
        MODE_BLOCK      = 3'd2,
        MODE_BLOCK_STAR = 3'd3,
        MODE_STRING     = 3'd4,
        MODE_STRING_ESC = 3'd5
    } t_mode;

    t_mode      r_mode, n_mode;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte, n_held_byte;

    logic [7:0] b;
    logic [7:0] y0, y1;
    logic [1:0] cnt;
    t_mode      mode_end;
    cbf_pkg::t_err err;

    always_comb begin
        b            = (i_item.in_byte == cbf_pkg::CH_CR) ? cbf_pkg::CH_SPACE : i_item.in_byte;
        mode_end     = r_mode;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        cnt          = 2'd0;
        y0           = cbf_pkg::CH_SPACE;
        y1           = cbf_pkg::CH_SPACE;
        unique case (r_mode)
            MODE_LINE: begin
                cnt = 2'd1;
                if (b == cbf_pkg::CH_LF) begin
                    y0       = b;
                    mode_end = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                cnt = 2'd1;
                y0  = cbf_pkg::blank(b);
                if (b == cbf_pkg::CH_STAR) begin
                    mode_end = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                cnt = 2'd1;
                y0  = cbf_pkg::blank(b);
                if (b == cbf_pkg::CH_SLASH) begin
                    mode_end = MODE_NORMAL;
                end else if (b != cbf_pkg::CH_STAR) begin
                    mode_end = MODE_BLOCK;
                end
            end
            MODE_STRING: begin
                cnt = 2'd1;
                y0  = b;
                if (b == cbf_pkg::CH_BSLASH) begin
                    mode_end = MODE_STRING_ESC;
                end else if (b == cbf_pkg::CH_QUOTE) begin
                    mode_end = MODE_NORMAL;
                end
            end
            MODE_STRING_ESC: begin
                cnt      = 2'd1;
                y0       = b;
                mode_end = MODE_STRING;
            end
            default: begin
                mode_end     = MODE_NORMAL;
                n_held_valid = 1'b0;
                if (r_held_valid && (b == cbf_pkg::CH_SLASH || b == cbf_pkg::CH_STAR)) begin
                    cnt      = 2'd2;
                    mode_end = (b == cbf_pkg::CH_SLASH) ? MODE_LINE : MODE_BLOCK_STAR;
                end else begin
                    y0 = r_held_byte;
                    if (b == cbf_pkg::CH_SLASH && !i_item.in_last) begin
                        n_held_valid = 1'b1;
                        n_held_byte  = b;
                        cnt          = r_held_valid ? 2'd1 : 2'd0;
                    end else begin
                        if (r_held_valid) begin
                            y1  = b;
                            cnt = 2'd2;
                        end else begin
                            y0  = b;
                            cnt = 2'd1;
                        end
                        if (b == cbf_pkg::CH_QUOTE) begin
                            mode_end = MODE_STRING;
                        end
                    end
                end
            end
        endcase

        if (mode_end == MODE_BLOCK || mode_end == MODE_BLOCK_STAR) begin
            err = cbf_pkg::ERR_OPEN_COMMENT;
        end else if (mode_end == MODE_STRING || mode_end == MODE_STRING_ESC) begin
            err = cbf_pkg::ERR_OPEN_STRING;
        end else begin
            err = cbf_pkg::ERR_OK;
        end

        n_mode = mode_end;
        if (i_item.in_last) begin
            n_mode       = MODE_NORMAL;
            n_held_valid = 1'b0;
            n_held_byte  = 8'h00;
        end

        o_push.count            = i_accept ? cnt : 2'd0;
        o_push.res0.out_byte    = y0;
        o_push.res0.out_last    = i_item.in_last && (cnt == 2'd1);
        o_push.res0.error_code  = (i_item.in_last && (cnt == 2'd1)) ? err : cbf_pkg::ERR_OK;
        o_push.res1.out_byte    = y1;
        o_push.res1.out_last    = i_item.in_last && (cnt == 2'd2);
        o_push.res1.error_code  = (i_item.in_last && (cnt == 2'd2)) ? err : cbf_pkg::ERR_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'h00;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
        end
    end

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.in_last |=> r_mode == MODE_NORMAL && !r_held_valid)
        else $error("state not cleared after final transaction");

    a_held_in_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> r_mode == MODE_NORMAL)
        else $error("byte held outside normal text");

    a_silent_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_push.count == 2'd0 |=> r_held_valid)
        else $error("transaction dropped without holding a byte");

endmodule

### hdl/cbf_out_fifo.sv
module cbf_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbf_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_stall,
    output cbf_pkg::t_out  o_data
);

    cbf_pkg::t_out r_mem [cbf_pkg::FIFO_DEPTH];

    logic [cbf_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [cbf_pkg::FIFO_CW-1:0] r_count;
    logic                        pop;
    logic [cbf_pkg::FIFO_AW-1:0] wr_ptr_1;

    assign pop      = o_valid && !i_stall;
    assign wr_ptr_1 = r_wr_ptr + cbf_pkg::FIFO_AW'(1);
    assign o_valid  = (r_count != '0);
    assign o_room   = (r_count <= cbf_pkg::FIFO_CW'(cbf_pkg::FIFO_DEPTH - 2));
    assign o_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + cbf_pkg::FIFO_AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + cbf_pkg::FIFO_AW'(pop);
            r_count  <= r_count + cbf_pkg::FIFO_CW'(i_push.count) - cbf_pkg::FIFO_CW'(pop);
        end
    end

endmodule

### hdl/comment_blanking_filter_unit.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall  | cbf_pkg::t_in  (in_byte, in_last)
// out     | output    | o_out_valid / i_out_stall| cbf_pkg::t_out (out_byte, out_last, error_code)
//
// One input transaction is taken per cycle while o_in_stall is low; it yields zero,
// one or two output transactions, written into a four-entry output queue at the edge
// that accepts it. The queue drains one transaction per cycle while i_out_stall is low.
// The input stalls only while the queue has fewer than two free entries.
// Synchronous active-low reset returns the scanner to normal text and empties the queue.
module comment_blanking_filter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cbf_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cbf_pkg::t_out o_out
);

    logic           room;
    logic           accept;
    cbf_pkg::t_push push;

    assign o_in_stall = !room;
    assign accept     = i_in_valid && room;

    cbf_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .o_push   (push)
    );

    cbf_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out)
    );

endmodule

### bench/comment_blanking_filter_unit_tb.sv
module comment_blanking_filter_unit_tb;
    import cbf_pkg::*;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_BLOCK_STAR,
        SCAN_STRING,
        SCAN_STRING_ESC
    } scan_mode_e;

    typedef struct {
        t_in  item;
        int   n_typed;
        t_out e0;
        t_out e1;
    } script_row_t;

    localparam int RANDOM_CHARS = 520;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out;

    scan_mode_e  scan_mode;
    logic [7:0]  held_char;
    logic        held_slash;
    t_out        blanked_q[$];
    script_row_t script[$];
    logic [7:0]  text_q[$];
    int          errors = 0;
    int          chars_sent = 0;
    bit          steady = 1'b0;

    comment_blanking_filter_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_out txt(input logic [7:0] b);
        return '{out_byte: b, out_last: 1'b0, error_code: ERR_OK};
    endfunction

    function automatic t_out fin(input logic [7:0] b, input t_err err);
        return '{out_byte: b, out_last: 1'b1, error_code: err};
    endfunction

    function automatic logic [7:0] keep_ws(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
            b == CH_FF || b == CH_CR) begin
            return b;
        end
        return CH_SPACE;
    endfunction

    task automatic scan_reset();
        scan_mode  = SCAN_TEXT;
        held_char  = 8'h00;
        held_slash = 1'b0;
    endtask

    task automatic add_expected(input t_out r);
        blanked_q = {blanked_q, r};
    endtask

    task automatic add_char(input logic [7:0] c);
        text_q = {text_q, c};
    endtask

    task automatic scan_char(input t_in item, output t_out res[2], output int n);
        logic [7:0] b;
        logic       opened;
        t_err       err;
        b = item.in_byte;
        opened = 1'b0;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (b == CH_CR) b = CH_SPACE;
        case (scan_mode)
            SCAN_LINE: begin
                if (b == CH_LF) begin
                    res[n++] = txt(b);
                    scan_mode = SCAN_TEXT;
                end else begin
                    res[n++] = txt(CH_SPACE);
                end
            end
            SCAN_BLOCK: begin
                res[n++] = txt(keep_ws(b));
                if (b == CH_STAR) scan_mode = SCAN_BLOCK_STAR;
            end
            SCAN_BLOCK_STAR: begin
                res[n++] = txt(keep_ws(b));
                if (b == CH_SLASH) scan_mode = SCAN_TEXT;
                else if (b != CH_STAR) scan_mode = SCAN_BLOCK;
            end
            SCAN_STRING: begin
                res[n++] = txt(b);
                if (b == CH_BSLASH) scan_mode = SCAN_STRING_ESC;
                else if (b == CH_QUOTE) scan_mode = SCAN_TEXT;
            end
            SCAN_STRING_ESC: begin
                res[n++] = txt(b);
                scan_mode = SCAN_STRING;
            end
            default: begin
                scan_mode = SCAN_TEXT;
                if (held_slash) begin
                    held_slash = 1'b0;
                    if (b == CH_SLASH || b == CH_STAR) begin
                        res[n++] = txt(CH_SPACE);
                        res[n++] = txt(CH_SPACE);
                        scan_mode = (b == CH_SLASH) ? SCAN_LINE : SCAN_BLOCK_STAR;
                        opened = 1'b1;
                    end else begin
                        res[n++] = txt(held_char);
                    end
                end
                if (!opened) begin
                    if (b == CH_SLASH && !item.in_last) begin
                        held_char  = b;
                        held_slash = 1'b1;
                    end else begin
                        res[n++] = txt(b);
                        if (b == CH_QUOTE) scan_mode = SCAN_STRING;
                    end
                end
            end
        endcase
        if (item.in_last && n > 0) begin
            if (scan_mode == SCAN_BLOCK || scan_mode == SCAN_BLOCK_STAR)
                err = ERR_OPEN_COMMENT;
            else if (scan_mode == SCAN_STRING || scan_mode == SCAN_STRING_ESC)
                err = ERR_OPEN_STRING;
            else
                err = ERR_OK;
            res[n-1].out_last = 1'b1;
            res[n-1].error_code = err;
            scan_reset();
        end
    endtask

    task automatic send_char(input t_in item, input int n_typed, input t_out e0,
                             input t_out e1);
        t_out res[2];
        int   n;
        while (!steady && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scan_char(item, res, n);
        if (n_typed < 0) begin
            for (int k = 0; k < n; k++) add_expected(res[k]);
        end else begin
            if (n_typed > 0) add_expected(e0);
            if (n_typed > 1) add_expected(e1);
        end
    endtask

    task automatic wait_drained();
        while (blanked_q.size() != 0) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input int n,
                           input t_out e0, input t_out e1);
        script_row_t row;
        row.item    = '{in_byte: b, in_last: last};
        row.n_typed = n;
        row.e0      = e0;
        row.e1      = e1;
        script = {script, row};
    endtask

    function automatic logic [7:0] body_char();
        case ($urandom_range(0, 15))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return CH_QUOTE;
            3:       return CH_BSLASH;
            4:       return CH_LF;
            5:       return CH_CR;
            6:       return CH_SPACE;
            7:       return CH_TAB;
            8:       return ($urandom_range(0, 1) != 0) ? CH_VT : CH_FF;
            9, 10:   return 8'($urandom_range(0, 255));
            default: return 8'h61 + 8'($urandom_range(0, 25));
        endcase
    endfunction

    task automatic build_text();
        int  frags;
        int  len;
        bit  closed;
        text_q.delete();
        frags = $urandom_range(1, 4);
        for (int f = 0; f < frags; f++) begin
            len = $urandom_range(0, 6);
            closed = ($urandom_range(0, 99) >= 15);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (int k = 0; k <= len; k++) add_char(body_char());
                end
                3, 4: begin
                    add_char(CH_SLASH);
                    add_char(CH_SLASH);
                    for (int k = 0; k < len; k++) add_char(body_char());
                    if (closed) add_char(CH_LF);
                end
                5, 6: begin
                    add_char(CH_SLASH);
                    add_char(CH_STAR);
                    for (int k = 0; k < len; k++) add_char(body_char());
                    if (closed) begin
                        add_char(CH_STAR);
                        add_char(CH_SLASH);
                    end
                end
                7, 8: begin
                    add_char(CH_QUOTE);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 4) == 0) add_char(CH_BSLASH);
                        add_char(body_char());
                    end
                    if (closed) add_char(CH_QUOTE);
                end
                default: begin
                    for (int k = 0; k <= len; k++)
                        add_char(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < 34);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blanked_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, actual %h", $time, o_out);
            end else begin
                want = blanked_q.pop_front();
                if (o_out.out_byte !== want.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h", $time,
                             want.out_byte, o_out.out_byte);
                end
                if (o_out.out_last !== want.out_last) begin
                    errors++;
                    $display("%0t: out_last expected %b actual %b", $time,
                             want.out_last, o_out.out_last);
                end
                if (o_out.error_code !== want.error_code) begin
                    errors++;
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             want.error_code, o_out.error_code);
                end
            end
        end
    end

    initial begin
        int texts;
        t_in item;
        texts = 0;
        scan_reset();

        add_row(8'h61,    1'b0,  1, txt(8'h61), '0);
        add_row(CH_CR,    1'b0,  1, txt(CH_SPACE), '0);
        add_row(8'hFF,    1'b0,  1, txt(8'hFF), '0);
        add_row(8'h00,    1'b1,  1, fin(8'h00, ERR_OK), '0);
        add_row(CH_SLASH, 1'b0,  0, '0, '0);
        add_row(CH_SLASH, 1'b0,  2, txt(CH_SPACE), txt(CH_SPACE));
        add_row(8'h78,    1'b0,  1, txt(CH_SPACE), '0);
        add_row(CH_LF,    1'b0,  1, txt(CH_LF), '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(CH_STAR,  1'b0, -1, '0, '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(CH_STAR,  1'b0, -1, '0, '0);
        add_row(CH_TAB,   1'b0, -1, '0, '0);
        add_row(CH_STAR,  1'b0, -1, '0, '0);
        add_row(CH_STAR,  1'b0, -1, '0, '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(CH_QUOTE, 1'b0, -1, '0, '0);
        add_row(CH_BSLASH, 1'b0, -1, '0, '0);
        add_row(CH_QUOTE, 1'b0, -1, '0, '0);
        add_row(CH_SLASH, 1'b1,  1, fin(CH_SLASH, ERR_OPEN_STRING), '0);
        add_row(CH_SLASH, 1'b0,  0, '0, '0);
        add_row(8'h71,    1'b1,  2, txt(CH_SLASH), fin(8'h71, ERR_OK));
        add_row(CH_SLASH, 1'b0,  0, '0, '0);
        add_row(CH_STAR,  1'b1,  2, txt(CH_SPACE), fin(CH_SPACE, ERR_OPEN_COMMENT));
        add_row(CH_SLASH, 1'b1,  1, fin(CH_SLASH, ERR_OK), '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(CH_SLASH, 1'b0, -1, '0, '0);
        add_row(8'h7A,    1'b1,  1, fin(CH_SPACE, ERR_OK), '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) send_char(script[r].item, script[r].n_typed, script[r].e0,
                                      script[r].e1);
        wait_drained();

        while (chars_sent < RANDOM_CHARS) begin
            build_text();
            foreach (text_q[k]) begin
                steady = (chars_sent >= 250 && chars_sent < 350);
                item.in_byte = text_q[k];
                item.in_last = (k == text_q.size() - 1);
                send_char(item, -1, '0, '0);
                chars_sent++;
            end
            texts++;
            if (texts % 10 == 0) wait_drained();
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        while (blanked_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && blanked_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
